// ===== hw/rtl/aabb_all_pairs_collision_macros.svh =====
// Assertion helpers shared by the collision detector RTL.
`ifndef AABB_ALL_PAIRS_COLLISION_MACROS_SVH
`define AABB_ALL_PAIRS_COLLISION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AABB_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AABB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/aabb_pkg.sv =====
`default_nettype none

package aabb_pkg;

  // Table size and layer mask width.
  localparam int MAX_BOXES  = 8;
  localparam int LAYER_BITS = 8;
  localparam int SLOT_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  // Stored layer masks keep only the low LAYER_BITS bits of the 8-bit field.
  localparam logic [7:0] LAYER_MASK =
      (LAYER_BITS >= 8) ? 8'hFF : 8'((1 << LAYER_BITS) - 1);

  typedef logic [2:0]          slot_t;
  typedef logic [SLOT_W-1:0]   idx_t;
  typedef logic signed [15:0]  coord_t;
  typedef logic [14:0]         extent_t;
  typedef logic [7:0]          layer_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SCAN   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_XAXIS,
    ST_YAXIS,
    ST_EMIT,
    ST_DONE
  } scan_state_e;

  // One slot of the box table.
  typedef struct packed {
    logic    enabled;
    logic    handler;
    coord_t  cx;
    coord_t  cy;
    extent_t w;
    extent_t h;
    layer_t  own;
    layer_t  tgt;
  } box_t;

  // Write or free command for the box table.
  typedef struct packed {
    logic wr;
    logic clr;
    idx_t idx;
  } tbl_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aabb_if.sv =====
`default_nettype none

// Input channel: one write, remove or scan item per transfer.
interface aabb_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [2:0]          slot;
  logic                box_enabled;
  logic                has_handler;
  logic signed [15:0]  center_x;
  logic signed [15:0]  center_y;
  logic [14:0]         box_width;
  logic [14:0]         box_height;
  logic [7:0]          own_layers;
  logic [7:0]          target_layers;

  modport source (
    output valid, operation, slot, box_enabled, has_handler, center_x, center_y,
           box_width, box_height, own_layers, target_layers,
    input  ready
  );
  modport sink (
    input  valid, operation, slot, box_enabled, has_handler, center_x, center_y,
           box_width, box_height, own_layers, target_layers,
    output ready
  );
endinterface

// Output channel: one collision event or scan completion per transfer.
interface aabb_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [2:0] target_slot;
  logic [7:0] source_layers;
  logic       last;

  modport source (
    output valid, hit, target_slot, source_layers, last,
    input  ready
  );
  modport sink (
    input  valid, hit, target_slot, source_layers, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/aabb_box_table.sv =====
`default_nettype none

module aabb_box_table (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  aabb_pkg::tbl_cmd_t     cmd_i,
  input  aabb_pkg::box_t         wr_entry_i,
  input  aabb_pkg::idx_t         src_idx_i,
  input  aabb_pkg::idx_t         tgt_idx_i,
  output logic [aabb_pkg::MAX_BOXES-1:0] valid_o,
  output aabb_pkg::box_t         src_entry_o,
  output aabb_pkg::box_t         tgt_entry_o
);
  import aabb_pkg::*;

  box_t                 mem [MAX_BOXES];
  logic [MAX_BOXES-1:0] valid_q;
  box_t                 src_q;
  box_t                 tgt_q;

  // Box storage: one write port, no reset, entries gated by the valid bits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[cmd_i.idx] <= wr_entry_i;
    end
  end

  // Two registered read ports, one for the source and one for the target.
  always_ff @(posedge clk_i) begin
    src_q <= mem[src_idx_i];
    tgt_q <= mem[tgt_idx_i];
  end

  // Valid bits are cleared at reset, set by a write and cleared by a remove.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.wr) begin
      valid_q[cmd_i.idx] <= 1'b1;
    end else if (cmd_i.clr) begin
      valid_q[cmd_i.idx] <= 1'b0;
    end
  end

  assign valid_o     = valid_q;
  assign src_entry_o = src_q;
  assign tgt_entry_o = tgt_q;

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_axis_unit.sv =====
`default_nettype none

// Overlap test on one axis. Two centered intervals overlap, edges touching
// included, when twice the center distance is at most the sum of the widths.
module aabb_axis_unit (
  input  aabb_pkg::coord_t  a_c_i,
  input  aabb_pkg::extent_t a_w_i,
  input  aabb_pkg::coord_t  b_c_i,
  input  aabb_pkg::extent_t b_w_i,
  output logic              overlap_o
);
  import aabb_pkg::*;

  logic signed [17:0] diff_ab;
  logic signed [17:0] diff_ba;
  logic        [15:0] wsum;
  logic signed [17:0] wsum_s;

  // Both center differences in parallel, sign-extended and already doubled.
  assign diff_ab = (18'(a_c_i) - 18'(b_c_i)) <<< 1;
  assign diff_ba = (18'(b_c_i) - 18'(a_c_i)) <<< 1;

  assign wsum   = {1'b0, a_w_i} + {1'b0, b_w_i};
  assign wsum_s = signed'({2'b00, wsum});

  assign overlap_o = (diff_ab <= wsum_s) && (diff_ba <= wsum_s);

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_all_pairs_collision.sv =====
`default_nettype none

`include "aabb_all_pairs_collision_macros.svh"

// All-pairs collision detector for centered axis-aligned boxes held in
// MAX_BOXES slots. A scan item walks every ordered (source, target) slot
// pair and is not ready for new input until its completion item has been
// loaded into the output register. Pairs run through one shared axis compare
// unit, x first and then y: a pair is skipped when its target slot is free
// or is the source itself, the layer, enable and handler filters can reject
// it after the x compare, a pair that passes them gets the y compare, and a
// hit goes on to the emit step; a free source slot skips all of its targets.
// Events come out in source-major slot order; the last item of every scan
// carries last=1, and a scan without events returns a single item with
// hit=0. The output register lets a finished item wait for the sink while
// the table takes further writes.
module aabb_all_pairs_collision (
  input  wire              clk_i,
  input  wire              rst_ni,
  aabb_in_if.sink          in_i,
  aabb_out_if.source       out_o
);
  import aabb_pkg::*;

  scan_state_e state_q, state_d;
  idx_t        src_q, src_d;
  idx_t        tgt_q, tgt_d;
  logic        xok_q, xok_d;

  logic        pend_valid_q, pend_valid_d;
  idx_t        pend_slot_q, pend_slot_d;
  layer_t      pend_layers_q, pend_layers_d;

  logic        out_valid_q, out_valid_d;
  logic        out_hit_q, out_hit_d;
  slot_t       out_slot_q, out_slot_d;
  layer_t      out_layers_q, out_layers_d;
  logic        out_last_q, out_last_d;

  tbl_cmd_t             tbl_cmd;
  box_t                 wr_entry;
  logic [MAX_BOXES-1:0] valid;
  box_t                 src_entry;
  box_t                 tgt_entry;

  coord_t      axis_a_c;
  coord_t      axis_b_c;
  extent_t     axis_a_w;
  extent_t     axis_b_w;
  logic        axis_ok;

  logic        in_xfer;
  logic        slot_in_range;
  logic        out_free;
  logic        pair_ok;
  logic        src_last;
  logic        tgt_last;
  idx_t        src_step;
  idx_t        tgt_step;

  logic        push;
  logic        push_hit;
  slot_t       push_slot;
  layer_t      push_layers;
  logic        push_last;

  assign in_i.ready    = (state_q == ST_IDLE);
  assign in_xfer       = in_i.valid && in_i.ready;
  assign slot_in_range = (int'(in_i.slot) < MAX_BOXES);
  assign out_free      = !out_valid_q || out_o.ready;

  // Entry built from the input item; layer masks are cut when stored.
  always_comb begin
    wr_entry.enabled = in_i.box_enabled;
    wr_entry.handler = in_i.has_handler;
    wr_entry.cx      = in_i.center_x;
    wr_entry.cy      = in_i.center_y;
    wr_entry.w       = in_i.box_width;
    wr_entry.h       = in_i.box_height;
    wr_entry.own     = in_i.own_layers & LAYER_MASK;
    wr_entry.tgt     = in_i.target_layers & LAYER_MASK;
  end

  // Table commands decoded from an accepted write or remove item.
  always_comb begin
    tbl_cmd.wr  = 1'b0;
    tbl_cmd.clr = 1'b0;
    tbl_cmd.idx = in_i.slot[SLOT_W-1:0];
    if (in_xfer && slot_in_range) begin
      unique case (op_e'(in_i.operation))
        OP_WRITE:  tbl_cmd.wr  = 1'b1;
        OP_REMOVE: tbl_cmd.clr = 1'b1;
        default:   ;
      endcase
    end
  end

  aabb_box_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (tbl_cmd),
    .wr_entry_i  (wr_entry),
    .src_idx_i   (src_q),
    .tgt_idx_i   (tgt_q),
    .valid_o     (valid),
    .src_entry_o (src_entry),
    .tgt_entry_o (tgt_entry)
  );

  // The shared compare unit sees x operands first and y operands next.
  always_comb begin
    if (state_q == ST_YAXIS) begin
      axis_a_c = src_entry.cy;
      axis_a_w = src_entry.h;
      axis_b_c = tgt_entry.cy;
      axis_b_w = tgt_entry.h;
    end else begin
      axis_a_c = src_entry.cx;
      axis_a_w = src_entry.w;
      axis_b_c = tgt_entry.cx;
      axis_b_w = tgt_entry.w;
    end
  end

  aabb_axis_unit u_axis (
    .a_c_i     (axis_a_c),
    .a_w_i     (axis_a_w),
    .b_c_i     (axis_b_c),
    .b_w_i     (axis_b_w),
    .overlap_o (axis_ok)
  );

  // Filters that do not need geometry; a target without a handler is
  // rejected up front since a hit on it reports nothing.
  assign pair_ok = src_entry.enabled && (src_entry.tgt != '0) &&
                   tgt_entry.enabled && tgt_entry.handler &&
                   ((src_entry.tgt & tgt_entry.own) != '0);

  // Pair cursor stepping.
  assign src_last = (src_q == idx_t'(MAX_BOXES - 1));
  assign tgt_last = (tgt_q == idx_t'(MAX_BOXES - 1));
  assign src_step = src_last ? '0 : src_q + idx_t'(1);
  assign tgt_step = tgt_last ? '0 : tgt_q + idx_t'(1);

  // Scan sequencer. One hit is held back as pending so that the final
  // event of a scan can be marked last once the walk is over.
  always_comb begin
    state_d       = state_q;
    src_d         = src_q;
    tgt_d         = tgt_q;
    xok_d         = xok_q;
    pend_valid_d  = pend_valid_q;
    pend_slot_d   = pend_slot_q;
    pend_layers_d = pend_layers_q;
    push          = 1'b0;
    push_hit      = 1'b1;
    push_slot     = slot_t'(pend_slot_q);
    push_layers   = pend_layers_q;
    push_last     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_i.operation == OP_SCAN)) begin
          src_d        = '0;
          tgt_d        = '0;
          pend_valid_d = 1'b0;
          state_d      = ST_READ;
        end
      end

      ST_READ: begin
        if (!valid[src_q]) begin
          // Free source slot: skip all of its targets.
          tgt_d   = '0;
          src_d   = src_step;
          state_d = src_last ? ST_DONE : ST_READ;
        end else if (!valid[tgt_q] || (tgt_q == src_q)) begin
          tgt_d   = tgt_step;
          src_d   = tgt_last ? src_step : src_q;
          state_d = (tgt_last && src_last) ? ST_DONE : ST_READ;
        end else begin
          state_d = ST_XAXIS;
        end
      end

      ST_XAXIS: begin
        xok_d = axis_ok;
        if (pair_ok) begin
          state_d = ST_YAXIS;
        end else begin
          tgt_d   = tgt_step;
          src_d   = tgt_last ? src_step : src_q;
          state_d = (tgt_last && src_last) ? ST_DONE : ST_READ;
        end
      end

      ST_YAXIS: begin
        if (xok_q && axis_ok) begin
          state_d = ST_EMIT;
        end else begin
          tgt_d   = tgt_step;
          src_d   = tgt_last ? src_step : src_q;
          state_d = (tgt_last && src_last) ? ST_DONE : ST_READ;
        end
      end

      ST_EMIT: begin
        // The earlier pending hit goes out, not last; this one takes its place.
        if (!pend_valid_q || out_free) begin
          push          = pend_valid_q;
          pend_valid_d  = 1'b1;
          pend_slot_d   = tgt_q;
          pend_layers_d = src_entry.own;
          tgt_d         = tgt_step;
          src_d         = tgt_last ? src_step : src_q;
          state_d       = (tgt_last && src_last) ? ST_DONE : ST_READ;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (!pend_valid_q) begin
            push_hit    = 1'b0;
            push_slot   = '0;
            push_layers = '0;
          end
          pend_valid_d = 1'b0;
          src_d        = '0;
          tgt_d        = '0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output register next state.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_hit_d    = out_hit_q;
    out_slot_d   = out_slot_q;
    out_layers_d = out_layers_q;
    out_last_d   = out_last_q;
    if (push) begin
      out_valid_d  = 1'b1;
      out_hit_d    = push_hit;
      out_slot_d   = push_slot;
      out_layers_d = push_layers;
      out_last_d   = push_last;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      src_q        <= '0;
      tgt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      src_q        <= src_d;
      tgt_q        <= tgt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    xok_q         <= xok_d;
    pend_slot_q   <= pend_slot_d;
    pend_layers_q <= pend_layers_d;
    out_hit_q     <= out_hit_d;
    out_slot_q    <= out_slot_d;
    out_layers_q  <= out_layers_d;
    out_last_q    <= out_last_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.hit           = out_hit_q;
  assign out_o.target_slot   = out_slot_q;
  assign out_o.source_layers = out_layers_q;
  assign out_o.last          = out_last_q;

  // A completion without events is last and carries zero fields.
  `AABB_ASSERT_IMPL(a_empty_completion, clk_i, rst_ni, out_valid_q && !out_hit_q, out_last_q && (out_slot_q == '0) && (out_layers_q == '0), "empty scan completion is malformed")
  // An accepted scan item starts the pair walk.
  `AABB_ASSERT_NEXT(a_scan_starts, clk_i, rst_ni, in_xfer && (in_i.operation == OP_SCAN), state_q == ST_READ, "scan transfer did not start the walk")
  // No hit may stay pending once the block is idle again.
  `AABB_ASSERT_IMPL(a_idle_no_pending, clk_i, rst_ni, state_q == ST_IDLE, !pend_valid_q, "pending hit left behind after a scan")
  // Closing a scan loads a last item and returns to idle.
  `AABB_ASSERT_NEXT(a_done_last, clk_i, rst_ni, (state_q == ST_DONE) && out_free, out_valid_q && out_last_q && (state_q == ST_IDLE), "scan closed without a last item")

endmodule

`default_nettype wire
